@@ sv/rmtf_pkg.sv @@
package rmtf_pkg;

    typedef enum logic [1:0] {
        OP_HEADER      = 2'd0,
        OP_DEQUEUE     = 2'd1,
        OP_CHAIN_SET   = 2'd2,
        OP_CHAIN_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        OUT_INVALID     = 3'd0,
        OUT_RING_SLOT   = 3'd1,
        OUT_SYNC_BUF    = 3'd2,
        OUT_CHAIN_DROP  = 3'd3,
        OUT_FULL_DROP   = 3'd4,
        OUT_DEQUEUED    = 3'd5,
        OUT_EMPTY       = 3'd6,
        OUT_CONTROL     = 3'd7
    } outcome_t;

    localparam logic [1:0] CFG_SYNC_MASK     = 2'd0;
    localparam logic [1:0] CFG_SLAVE_MASK    = 2'd1;
    localparam logic [1:0] CFG_RESERVED      = 2'd2;

    localparam logic [7:0] SYNC_MASK_RST     = 8'h40;
    localparam logic [7:0] SLAVE_MASK_RST    = 8'h20;
    localparam logic [3:0] RESERVED_RST      = 4'd2;

    localparam logic [7:0] INVALID_BIT       = 8'h80;

    // stored frame header: command id in the high byte
    typedef struct packed {
        logic [7:0] command_id;
        logic [7:0] frame_length;
    } hdr_t;

endpackage

@@ sv/rmtf_hdr_mem.sv @@
module rmtf_hdr_mem
    import rmtf_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  hdr_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output hdr_t          rd_data
);

    hdr_t mem [DEPTH];
    hdr_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/rx_message_triage_fifo.sv @@
// Receive-side header triage and slot ring. Each request (frame header, dequeue,
// or chain-pending control) is decided in the cycle it is accepted and its result
// appears in the output register in the next cycle; a request can be accepted every
// cycle, and in_stall rises only while a finished result is held by out_stall.
// Headers live in a RING_DEPTH-entry memory with one write and one registered
// read port, which returns the dequeued header with the result. Status outputs
// reflect the ring after the request; peak_level is the high watermark since reset.
module rx_message_triage_fifo
    import rmtf_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] command_id,
    input  logic [7:0] frame_length,
    input  logic       sync_wait_armed,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] outcome,
    output logic [3:0] slot_index,
    output logic [7:0] head_command_id,
    output logic [7:0] head_length,
    output logic       is_empty,
    output logic       is_full,
    output logic       is_almost_full,
    output logic [4:0] fill_level,
    output logic [4:0] peak_level
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int FREE_W = (PTR_W + 1 > 4) ? PTR_W + 1 : 4;
    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(RING_DEPTH - 1);
    localparam logic [FREE_W-1:0] DEPTH_FREE = FREE_W'(RING_DEPTH);

    // configuration
    logic [7:0] sync_mask_reg;
    logic [7:0] slave_mask_reg;
    logic [3:0] reserved_reg;

    // ring state
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic             chain_reg, chain_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    outcome_t         outcome_reg, outcome_next;
    logic [3:0]       slot_reg, slot_next;
    logic             empty_reg, empty_next;
    logic             full_o_reg;
    logic             almost_reg, almost_next;
    logic [4:0]       fill_reg, fill_next;
    logic [4:0]       peak_o_reg, peak_o_next;

    logic             accept;
    logic             mem_wr_en;
    logic             mem_rd_en;
    hdr_t             wr_hdr;
    hdr_t             rd_hdr;
    opcode_t          op;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op       = opcode_t'(opcode);
    assign wr_hdr   = '{command_id: command_id, frame_length: frame_length};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mask_reg  <= SYNC_MASK_RST;
            slave_mask_reg <= SLAVE_MASK_RST;
            reserved_reg   <= RESERVED_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SYNC_MASK:  sync_mask_reg  <= cfg_data;
                CFG_SLAVE_MASK: slave_mask_reg <= cfg_data;
                CFG_RESERVED:   reserved_reg   <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic [PTR_W-1:0]   wr_inc;
        logic [PTR_W-1:0]   rd_inc;
        logic [FREE_W-1:0]  rd_f;
        logic [FREE_W-1:0]  wr_f;
        logic [FREE_W-1:0]  free_slots;
        logic [PTR_W+3:0]   slot_ext;
        logic [CNT_W+4:0]   occ_ext;
        logic [CNT_W+4:0]   peak_ext;
        logic [PTR_W-1:0]   slot_sel;
        logic               cur_empty;

        wr_inc    = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_inc    = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        cur_empty = (rd_ptr_reg == wr_ptr_reg) && !full_reg;

        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        full_next    = full_reg;
        occ_next     = occ_reg;
        peak_next    = peak_reg;
        chain_next   = chain_reg;
        outcome_next = OUT_INVALID;
        slot_sel     = '0;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;

        unique case (op)
            OP_HEADER:
            begin
                priority if (((command_id & INVALID_BIT) != 8'd0)
                             || ((command_id & slave_mask_reg) == 8'd0))
                begin
                    outcome_next = OUT_INVALID;
                end
                else if ((command_id & sync_mask_reg) != 8'd0)
                begin
                    if (chain_reg)
                    begin
                        chain_next   = 1'b0;
                        outcome_next = OUT_CHAIN_DROP;
                    end
                    else
                    begin
                        outcome_next = sync_wait_armed ? OUT_SYNC_BUF : OUT_INVALID;
                    end
                end
                else if (full_reg)
                begin
                    outcome_next = OUT_FULL_DROP;
                end
                else
                begin
                    mem_wr_en    = accept;
                    slot_sel     = wr_ptr_reg;
                    wr_ptr_next  = wr_inc;
                    occ_next     = occ_reg + CNT_W'(1);
                    peak_next    = (occ_next > peak_reg) ? occ_next : peak_reg;
                    full_next    = (wr_inc == rd_ptr_reg);
                    outcome_next = OUT_RING_SLOT;
                end
            end
            OP_DEQUEUE:
            begin
                if (cur_empty)
                begin
                    outcome_next = OUT_EMPTY;
                end
                else
                begin
                    mem_rd_en    = accept;
                    slot_sel     = rd_ptr_reg;
                    rd_ptr_next  = rd_inc;
                    full_next    = 1'b0;
                    occ_next     = (occ_reg != '0) ? occ_reg - CNT_W'(1) : occ_reg;
                    outcome_next = OUT_DEQUEUED;
                end
            end
            OP_CHAIN_SET, OP_CHAIN_CLEAR:
            begin
                chain_next   = (op == OP_CHAIN_SET);
                outcome_next = OUT_CONTROL;
            end
        endcase

        if (!accept)
        begin
            rd_ptr_next = rd_ptr_reg;
            wr_ptr_next = wr_ptr_reg;
            full_next   = full_reg;
            occ_next    = occ_reg;
            peak_next   = peak_reg;
            chain_next  = chain_reg;
        end

        // status after the request
        rd_f       = FREE_W'(rd_ptr_next);
        wr_f       = FREE_W'(wr_ptr_next);
        free_slots = (rd_f >= wr_f) ? rd_f - wr_f : rd_f + DEPTH_FREE - wr_f;
        empty_next = (rd_ptr_next == wr_ptr_next) && !full_next;
        if (sync_wait_armed)
        begin
            almost_next = full_next;
        end
        else
        begin
            almost_next = full_next || ((free_slots != '0)
                          && (free_slots <= FREE_W'(reserved_reg)));
        end

        slot_ext    = {4'd0, slot_sel};
        occ_ext     = {5'd0, occ_next};
        peak_ext    = {5'd0, peak_next};
        slot_next   = slot_ext[3:0];
        fill_next   = occ_ext[4:0];
        peak_o_next = peak_ext[4:0];

        out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            full_reg      <= 1'b0;
            occ_reg       <= '0;
            peak_reg      <= '0;
            chain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            full_reg      <= full_next;
            occ_reg       <= occ_next;
            peak_reg      <= peak_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            outcome_reg <= outcome_next;
            slot_reg    <= slot_next;
            empty_reg   <= empty_next;
            full_o_reg  <= full_next;
            almost_reg  <= almost_next;
            fill_reg    <= fill_next;
            peak_o_reg  <= peak_o_next;
        end
    end

    rmtf_hdr_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (PTR_W)
    ) u_hdr_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_hdr),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_hdr)
    );

    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign slot_index      = slot_reg;
    assign head_command_id = (outcome_reg == OUT_DEQUEUED) ? rd_hdr.command_id : 8'd0;
    assign head_length     = (outcome_reg == OUT_DEQUEUED) ? rd_hdr.frame_length : 8'd0;
    assign is_empty        = empty_reg;
    assign is_full         = full_o_reg;
    assign is_almost_full  = almost_reg;
    assign fill_level      = fill_reg;
    assign peak_level      = peak_o_reg;

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (occ_reg == CNT_W'(RING_DEPTH)))
        else $error("full flag without full occupancy");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((rd_ptr_reg == wr_ptr_reg) && !full_reg) |-> (occ_reg == '0))
        else $error("empty ring with nonzero occupancy");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= occ_reg)
        else $error("peak below occupancy");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no result held");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (!full_reg && !mem_rd_en))
        else $error("header written into full ring");

endmodule
